@@ hw/rtl/rfrc_pkg.sv @@
// ----------------------------------------------------------------------------
// rfrc_pkg
// shared types, constants and round functions of the remote code cipher
// ----------------------------------------------------------------------------
package rfrc_pkg;

  localparam int NUM_KNOWN_REMOTES = 4;
  localparam int REG_REMOTES       = 4;
  localparam int NUM_CMP = (NUM_KNOWN_REMOTES < REG_REMOTES) ? NUM_KNOWN_REMOTES : REG_REMOTES;

  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_VALIDATE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_REMOTE_0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REMOTE_1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REMOTE_2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REMOTE_3 = 3'd4;

  localparam logic [3:0] TOP_NIB_XOR = 4'h9;

  typedef enum logic [1:0] {
    CMD_ENC28 = 2'd0,
    CMD_DEC28 = 2'd1,
    CMD_ENC32 = 2'd2,
    CMD_DEC32 = 2'd3
  } cmd_t;

  typedef logic [3:0] box_t [16];

  localparam box_t ENC_BOX = '{4'd9, 4'd6, 4'd3, 4'd8, 4'd10, 4'd0, 4'd2, 4'd12,
                               4'd4, 4'd14, 4'd7, 4'd5, 4'd1, 4'd15, 4'd11, 4'd13};
  localparam box_t DEC_BOX = '{4'd5, 4'd12, 4'd6, 4'd2, 4'd8, 4'd11, 4'd1, 4'd10,
                               4'd3, 4'd0, 4'd4, 4'd14, 4'd7, 4'd15, 4'd9, 4'd13};

  typedef struct packed {
    logic        valid;
    cmd_t        cmd;
    logic [31:0] word;
  } stage_t;

  typedef struct packed {
    logic                        validate;
    logic [REG_REMOTES-1:0][15:0] remote;
  } cfg_t;

  // chained substitution over the low six nibbles
  function automatic logic [23:0] enc_round(logic [23:0] nb, logic bump);
    logic [23:0] r;
    logic [3:0]  idx;
    r   = '0;
    idx = nb[3:0] + {3'b000, bump};
    r[3:0] = ENC_BOX[idx];
    for (int k = 1; k < 6; k++) begin
      idx = (nb[4*k +: 4] ^ r[4*(k-1) +: 4]) + {3'b000, bump};
      r[4*k +: 4] = ENC_BOX[idx];
    end
    return r;
  endfunction

  // inverse round, each nibble uses the previous round's neighbor
  function automatic logic [23:0] dec_round(logic [23:0] nb, logic bump);
    logic [23:0] r;
    r = '0;
    r[3:0] = DEC_BOX[nb[3:0]] - {3'b000, bump};
    for (int k = 1; k < 6; k++) begin
      r[4*k +: 4] = (DEC_BOX[nb[4*k +: 4]] - {3'b000, bump}) ^ nb[4*(k-1) +: 4];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/rfrc_in_if.sv @@
// ----------------------------------------------------------------------------
// rfrc_in_if
// request channel: one item to encode or decode
// ----------------------------------------------------------------------------
interface rfrc_in_if;
  logic              valid;
  logic              ready;
  rfrc_pkg::cmd_t    command;
  logic [31:0]       raw_code;
  logic [15:0]       transmitter_id;
  logic [3:0]        channel;
  logic [3:0]        button_command;
  logic [3:0]        payload;
  logic [1:0]        rolling_id;

  modport source (output valid, command, raw_code, transmitter_id, channel,
                  button_command, payload, rolling_id, input ready);
  modport sink   (input valid, command, raw_code, transmitter_id, channel,
                  button_command, payload, rolling_id, output ready);
endinterface

@@ hw/rtl/rfrc_out_if.sv @@
// ----------------------------------------------------------------------------
// rfrc_out_if
// result channel: code word and decoded fields of one item
// ----------------------------------------------------------------------------
interface rfrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_word;
  logic [15:0] transmitter_out;
  logic [3:0]  channel_out;
  logic [3:0]  button_out;
  logic [3:0]  payload_out;
  logic [1:0]  rolling_out;
  logic        accepted;

  modport source (output valid, code_word, transmitter_out, channel_out, button_out,
                  payload_out, rolling_out, accepted, input ready);
  modport sink   (input valid, code_word, transmitter_out, channel_out, button_out,
                  payload_out, rolling_out, accepted, output ready);
endinterface

@@ hw/rtl/rfrc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rfrc_cfg_regs
// apb register file: validation enable and known remote identifiers
// ----------------------------------------------------------------------------
module rfrc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rfrc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output rfrc_pkg::cfg_t              cfg
);

  logic [rfrc_pkg::REG_IDX_W-1:0] idx;
  logic                           wr;

  assign idx    = paddr[rfrc_pkg::ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        rfrc_pkg::REG_VALIDATE: cfg.validate  <= pwdata[0];
        rfrc_pkg::REG_REMOTE_0: cfg.remote[0] <= pwdata[15:0];
        rfrc_pkg::REG_REMOTE_1: cfg.remote[1] <= pwdata[15:0];
        rfrc_pkg::REG_REMOTE_2: cfg.remote[2] <= pwdata[15:0];
        rfrc_pkg::REG_REMOTE_3: cfg.remote[3] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rfrc_pkg::REG_VALIDATE: prdata = {31'b0, cfg.validate};
      rfrc_pkg::REG_REMOTE_0: prdata = {16'b0, cfg.remote[0]};
      rfrc_pkg::REG_REMOTE_1: prdata = {16'b0, cfg.remote[1]};
      rfrc_pkg::REG_REMOTE_2: prdata = {16'b0, cfg.remote[2]};
      rfrc_pkg::REG_REMOTE_3: prdata = {16'b0, cfg.remote[3]};
      default:                prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/rfrc_front.sv @@
// ----------------------------------------------------------------------------
// rfrc_front
// first stage: field packing, rotation and, for the 28-bit modes, the first cipher round
// ----------------------------------------------------------------------------
module rfrc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  rfrc_in_if.sink           req,
  output rfrc_pkg::stage_t  st
);

  rfrc_pkg::stage_t st_next;
  logic [27:0]      msg28;
  logic [27:0]      rot28;

  assign req.ready = advance;

  always_comb begin
    msg28 = {req.payload, req.transmitter_id, req.rolling_id, req.button_command[1:0],
             req.channel};
    rot28 = {req.raw_code[25:0], req.raw_code[27:26]};
    st_next.valid = req.valid;
    st_next.cmd   = req.command;
    case (req.command)
      rfrc_pkg::CMD_ENC28: st_next.word = {4'b0, msg28[27:24],
                                           rfrc_pkg::enc_round(msg28[23:0], 1'b1)};
      rfrc_pkg::CMD_DEC28: st_next.word = {4'b0, rot28[27:24] ^ rfrc_pkg::TOP_NIB_XOR,
                                           rfrc_pkg::dec_round(rot28[23:0], 1'b0)};
      rfrc_pkg::CMD_ENC32: st_next.word = {4'b0, req.payload, req.transmitter_id,
                                           req.button_command, req.channel};
      default:             st_next.word = req.raw_code;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

endmodule

@@ hw/rtl/rfrc_round.sv @@
// ----------------------------------------------------------------------------
// rfrc_round
// second stage: the second cipher round for the 28-bit modes
// ----------------------------------------------------------------------------
module rfrc_round (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  rfrc_pkg::stage_t  st_in,
  output rfrc_pkg::stage_t  st
);

  rfrc_pkg::stage_t st_next;

  always_comb begin
    st_next = st_in;
    case (st_in.cmd)
      rfrc_pkg::CMD_ENC28: st_next.word[23:0] = rfrc_pkg::enc_round(st_in.word[23:0], 1'b0);
      rfrc_pkg::CMD_DEC28: st_next.word[23:0] = rfrc_pkg::dec_round(st_in.word[23:0], 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

endmodule

@@ hw/rtl/rfrc_back.sv @@
// ----------------------------------------------------------------------------
// rfrc_back
// last stage: output rotation, field unpacking, remote check, result register
// ----------------------------------------------------------------------------
module rfrc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  rfrc_pkg::stage_t  st_in,
  input  rfrc_pkg::cfg_t    cfg,
  rfrc_out_if.source        rsp
);

  logic [27:0] w28;
  logic [31:0] code_next;
  logic [15:0] tx_next;
  logic [3:0]  ch_next;
  logic [3:0]  btn_next;
  logic [3:0]  pay_next;
  logic [1:0]  roll_next;
  logic        acc_next;
  logic        match;

  always_comb begin
    w28   = {st_in.word[27:24] ^ rfrc_pkg::TOP_NIB_XOR, st_in.word[23:0]};
    match = 1'b0;
    for (int k = 0; k < rfrc_pkg::NUM_CMP; k++) begin
      if (cfg.remote[k] == st_in.word[23:8]) match = 1'b1;
    end
    code_next = st_in.word;
    tx_next   = st_in.word[23:8];
    ch_next   = st_in.word[3:0];
    btn_next  = st_in.word[7:4];
    pay_next  = st_in.word[27:24];
    roll_next = 2'b00;
    acc_next  = ~cfg.validate | match;
    case (st_in.cmd)
      rfrc_pkg::CMD_ENC28: begin
        code_next = {4'b0, w28[1:0], w28[27:2]};
        tx_next   = '0;
        ch_next   = '0;
        btn_next  = '0;
        pay_next  = '0;
        acc_next  = 1'b1;
      end
      rfrc_pkg::CMD_ENC32: begin
        tx_next  = '0;
        ch_next  = '0;
        btn_next = '0;
        pay_next = '0;
        acc_next = 1'b1;
      end
      rfrc_pkg::CMD_DEC28: begin
        btn_next  = {2'b00, st_in.word[5:4]};
        roll_next = st_in.word[7:6];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid           <= st_in.valid;
      rsp.code_word       <= code_next;
      rsp.transmitter_out <= tx_next;
      rsp.channel_out     <= ch_next;
      rsp.button_out      <= btn_next;
      rsp.payload_out     <= pay_next;
      rsp.rolling_out     <= roll_next;
      rsp.accepted        <= acc_next;
    end
  end

endmodule

@@ hw/rtl/rf_remote_code_cipher.sv @@
// ----------------------------------------------------------------------------
// rf_remote_code_cipher
// three-stage codec for 28-bit scrambled and 32-bit plain remote codes
// ----------------------------------------------------------------------------
//  channel  dir  handshake           contents
//  req      in   valid/ready         command, raw code, encode fields
//  rsp      out  valid/ready         code word, decoded fields, accepted
//  apb      in   psel/penable/pready validate enable, four known remotes
//
//  one item per cycle unless the result stalls; each item passes in turn
//  through pack and first round, second round, unpack and remote compare
//  all stages move together; a stalled result holds every stage in place
//  rst is synchronous and clears the valid bits and the configuration registers
// ----------------------------------------------------------------------------
module rf_remote_code_cipher (
  input  logic                        clk,
  input  logic                        rst,
  rfrc_in_if.sink                     req,
  rfrc_out_if.source                  rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rfrc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  rfrc_pkg::cfg_t   cfg;
  rfrc_pkg::stage_t st1;
  rfrc_pkg::stage_t st2;
  logic             advance;

  assign advance = ~rsp.valid | rsp.ready;

  rfrc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rfrc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .req     (req),
    .st      (st1)
  );

  rfrc_round u_round (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .st_in   (st1),
    .st      (st2)
  );

  rfrc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .st_in   (st2),
    .cfg     (cfg),
    .rsp     (rsp)
  );

endmodule

@@ bench/rf_remote_code_cipher_tb.sv @@
// ----------------------------------------------------------------------------
// rf_remote_code_cipher_tb
// checks the remote code cipher against an in-bench scramble/unscramble
// predictor: directed corner items, then round-trip and random codes under
// several remote-list settings, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module rf_remote_code_cipher_tb;
  import rfrc_pkg::*;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          IDLE_PCT     = 32;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          RANDOM_ITEMS = 92;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [3:0]  TOP_FLIP     = 4'h9;
  localparam logic [63:0] FWD_SUB      = 64'hDBF1_57E4_C20A_8369;
  localparam logic [63:0] INV_SUB      = 64'hD9F7_E403_A1B8_26C5;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] raw_code;
    logic [15:0] transmitter_id;
    logic [3:0]  channel;
    logic [3:0]  button_command;
    logic [3:0]  payload;
    logic [1:0]  rolling_id;
  } code_request_t;

  typedef struct packed {
    logic [31:0] code_word;
    logic [15:0] transmitter_out;
    logic [3:0]  channel_out;
    logic [3:0]  button_out;
    logic [3:0]  payload_out;
    logic [1:0]  rolling_out;
    logic        accepted;
  } code_result_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  rfrc_in_if  req_ch ();
  rfrc_out_if rsp_ch ();

  rf_remote_code_cipher uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  code_request_t code_requests [$];
  code_result_t  expected_codes [$];
  code_request_t next_request;
  code_request_t seen_request;
  code_result_t  want;
  code_result_t  got;
  logic          cfg_validate;
  logic [15:0]   cfg_remote [REG_REMOTES];
  logic          req_taken;
  logic          steady;
  int            queued_count;
  int            sent_count;
  int            errors;
  int            cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [27:0] pack28(logic [3:0] pay, logic [15:0] tx, logic [1:0] roll,
                                         logic [3:0] btn, logic [3:0] ch);
    return {pay, tx, roll, btn[1:0], ch};
  endfunction

  function automatic logic [27:0] scramble28(logic [27:0] msg);
    logic [3:0]  nb [7];
    logic [3:0]  idx;
    logic [3:0]  bump;
    logic [27:0] w;
    for (int k = 0; k < 7; k++) nb[k] = msg[4*k +: 4];
    for (int rnd = 0; rnd < 2; rnd++) begin
      bump  = (rnd == 0) ? 4'd1 : 4'd0;
      idx   = nb[0] + bump;
      nb[0] = FWD_SUB[4*idx +: 4];
      for (int k = 1; k < 6; k++) begin
        idx   = (nb[k] ^ nb[k-1]) + bump;
        nb[k] = FWD_SUB[4*idx +: 4];
      end
    end
    nb[6] = nb[6] ^ TOP_FLIP;
    w = {nb[6], nb[5], nb[4], nb[3], nb[2], nb[1], nb[0]};
    return {w[1:0], w[27:2]};
  endfunction

  function automatic logic [27:0] unscramble28(logic [27:0] code);
    logic [3:0]  nb [7];
    logic [3:0]  drop;
    logic [27:0] w;
    w = {code[25:0], code[27:26]};
    for (int k = 0; k < 7; k++) nb[k] = w[4*k +: 4];
    nb[6] = nb[6] ^ TOP_FLIP;
    for (int rnd = 0; rnd < 2; rnd++) begin
      drop = (rnd == 1) ? 4'd1 : 4'd0;
      for (int k = 5; k >= 1; k--) nb[k] = (INV_SUB[4*nb[k] +: 4] - drop) ^ nb[k-1];
      nb[0] = INV_SUB[4*nb[0] +: 4] - drop;
    end
    return {nb[6], nb[5], nb[4], nb[3], nb[2], nb[1], nb[0]};
  endfunction

  function automatic code_result_t predict_code_result(code_request_t rq);
    code_result_t r;
    logic [27:0]  msg;
    logic         known;
    r = '0;
    r.accepted = 1'b1;
    case (rq.command)
      CMD_ENC28: begin
        r.code_word = {4'h0, scramble28(pack28(rq.payload, rq.transmitter_id, rq.rolling_id,
                                               rq.button_command, rq.channel))};
      end
      CMD_ENC32: begin
        r.code_word = {4'h0, rq.payload, rq.transmitter_id, rq.button_command, rq.channel};
      end
      default: begin
        if (rq.command == CMD_DEC28) begin
          msg           = unscramble28(rq.raw_code[27:0]);
          r.code_word   = {4'h0, msg};
          r.button_out  = {2'b00, msg[5:4]};
          r.rolling_out = msg[7:6];
        end else begin
          r.code_word   = rq.raw_code;
          r.button_out  = rq.raw_code[7:4];
        end
        r.transmitter_out = r.code_word[23:8];
        r.channel_out     = r.code_word[3:0];
        r.payload_out     = r.code_word[27:24];
        known = 1'b0;
        for (int k = 0; k < NUM_CMP; k++)
          if (cfg_remote[k] == r.transmitter_out) known = 1'b1;
        r.accepted = !cfg_validate || known;
      end
    endcase
    return r;
  endfunction

  function automatic code_request_t make_request(cmd_t cmd, logic [31:0] raw, logic [15:0] tx,
                                                 logic [3:0] ch, logic [3:0] btn,
                                                 logic [3:0] pay, logic [1:0] roll);
    code_request_t rq;
    rq.command        = cmd;
    rq.raw_code       = raw;
    rq.transmitter_id = tx;
    rq.channel        = ch;
    rq.button_command = btn;
    rq.payload        = pay;
    rq.rolling_id     = roll;
    return rq;
  endfunction

  // decode items mostly carry well-formed codes, many from known remotes
  function automatic code_request_t random_request();
    code_request_t rq;
    logic [15:0]   tx;
    rq = make_request(cmd_t'($urandom_range(3)), $urandom, 16'($urandom), 4'($urandom),
                      4'($urandom), 4'($urandom), 2'($urandom));
    if ((rq.command == CMD_DEC28 || rq.command == CMD_DEC32) && $urandom_range(99) < 65) begin
      tx = ($urandom_range(3) == 0) ? 16'($urandom) : cfg_remote[$urandom_range(REG_REMOTES-1)];
      rq.transmitter_id = tx;
      if (rq.command == CMD_DEC28)
        rq.raw_code = {rq.raw_code[31:28], scramble28(pack28(rq.payload, tx, rq.rolling_id,
                                                             rq.button_command, rq.channel))};
      else
        rq.raw_code = {rq.raw_code[31:28], rq.payload, tx, rq.button_command, rq.channel};
    end
    return rq;
  endfunction

  task automatic queue_request(code_request_t rq);
    code_requests.push_back(rq);
    queued_count++;
  endtask

  task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_VALIDATE) cfg_validate = value[0];
    else cfg_remote[idx - REG_REMOTE_0] = value[15:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_config(logic en, logic [15:0] r0, logic [15:0] r1, logic [15:0] r2,
                             logic [15:0] r3);
    write_register(REG_VALIDATE, ($urandom & 32'hFFFF_FFFE) | {31'd0, en});
    write_register(REG_REMOTE_0, {16'($urandom), r0});
    write_register(REG_REMOTE_1, {16'($urandom), r1});
    write_register(REG_REMOTE_2, {16'($urandom), r2});
    write_register(REG_REMOTE_3, {16'($urandom), r3});
  endtask

  task automatic drain_pipeline();
    while (sent_count != queued_count || expected_codes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (code_requests.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        next_request = code_requests.pop_front();
        req_ch.command        <= next_request.command;
        req_ch.raw_code       <= next_request.raw_code;
        req_ch.transmitter_id <= next_request.transmitter_id;
        req_ch.channel        <= next_request.channel;
        req_ch.button_command <= next_request.button_command;
        req_ch.payload        <= next_request.payload;
        req_ch.rolling_id     <= next_request.rolling_id;
        req_ch.valid          <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // accepted items and results
  always @(posedge clk) begin
    req_taken = !rst && req_ch.valid && req_ch.ready;
    if (req_taken) begin
      seen_request = make_request(req_ch.command, req_ch.raw_code, req_ch.transmitter_id,
                                  req_ch.channel, req_ch.button_command, req_ch.payload,
                                  req_ch.rolling_id);
      expected_codes.push_back(predict_code_result(seen_request));
      sent_count++;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.code_word       = rsp_ch.code_word;
      got.transmitter_out = rsp_ch.transmitter_out;
      got.channel_out     = rsp_ch.channel_out;
      got.button_out      = rsp_ch.button_out;
      got.payload_out     = rsp_ch.payload_out;
      got.rolling_out     = rsp_ch.rolling_out;
      got.accepted        = rsp_ch.accepted;
      if (expected_codes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("cycle %0d: result with nothing outstanding, code %h", cycle_count,
                   got.code_word);
      end else begin
        want = expected_codes.pop_front();
        if (got.code_word !== want.code_word || got.transmitter_out !== want.transmitter_out ||
            got.channel_out !== want.channel_out || got.button_out !== want.button_out ||
            got.payload_out !== want.payload_out || got.rolling_out !== want.rolling_out ||
            got.accepted !== want.accepted) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("cycle %0d: expected code %h tx %h ch %h btn %h pay %h roll %h acc %b",
                     cycle_count, want.code_word, want.transmitter_out, want.channel_out,
                     want.button_out, want.payload_out, want.rolling_out, want.accepted);
            $display("cycle %0d: got      code %h tx %h ch %h btn %h pay %h roll %h acc %b",
                     cycle_count, got.code_word, got.transmitter_out, got.channel_out,
                     got.button_out, got.payload_out, got.rolling_out, got.accepted);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** rf_remote_code_cipher: FAILED **");
      $finish;
    end
  end

  initial begin
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    req_ch.valid          = 1'b0;
    req_ch.command        = CMD_ENC28;
    req_ch.raw_code       = '0;
    req_ch.transmitter_id = '0;
    req_ch.channel        = '0;
    req_ch.button_command = '0;
    req_ch.payload        = '0;
    req_ch.rolling_id     = '0;
    rsp_ch.ready          = 1'b0;
    req_taken             = 1'b0;
    steady                = 1'b0;
    cfg_validate          = 1'b0;
    for (int k = 0; k < REG_REMOTES; k++) cfg_remote[k] = '0;
    queued_count          = 0;
    sent_count            = 0;
    errors                = 0;
    cycle_count           = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, validation off
    queue_request(make_request(CMD_ENC28, 32'h0, 16'h0000, 4'h0, 4'h0, 4'h0, 2'd0));
    queue_request(make_request(CMD_ENC28, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 4'hF, 4'hF, 2'd3));
    queue_request(make_request(CMD_ENC28, 32'h0, 16'h0000, 4'h0, 4'hC, 4'h0, 2'd0));
    queue_request(make_request(CMD_ENC32, 32'hFFFF_FFFF, 16'h0000, 4'h0, 4'h0, 4'h0, 2'd0));
    queue_request(make_request(CMD_ENC32, 32'h0, 16'hFFFF, 4'hF, 4'hF, 4'hF, 2'd3));
    queue_request(make_request(CMD_DEC28, 32'h0000_0000, 16'h0, 4'h0, 4'h0, 4'h0, 2'd0));
    queue_request(make_request(CMD_DEC28, 32'hFFFF_FFFF, 16'h0, 4'h0, 4'h0, 4'h0, 2'd0));
    queue_request(make_request(CMD_DEC28, 32'hF000_0000, 16'h0, 4'h0, 4'h0, 4'h0, 2'd0));
    queue_request(make_request(CMD_DEC32, 32'h0000_0000, 16'h0, 4'h0, 4'h0, 4'h0, 2'd0));
    queue_request(make_request(CMD_DEC32, 32'hFFFF_FFFF, 16'h0, 4'h0, 4'h0, 4'h0, 2'd0));
    queue_request(make_request(CMD_DEC32, 32'hA5C3_9E17, 16'h0, 4'h0, 4'h0, 4'h0, 2'd0));
    drain_pipeline();

    // validation on: known and unknown transmitters, rejected ones keep their fields
    load_config(1'b1, 16'h0000, 16'hFFFF, 16'h5A5A, 16'hC3C3);
    queue_request(make_request(CMD_DEC32, {4'h3, 4'h7, 16'h5A5A, 8'h9E}, 16'h0, 4'h0, 4'h0,
                               4'h0, 2'd0));
    queue_request(make_request(CMD_DEC32, {4'hC, 4'h2, 16'h1111, 8'h4B}, 16'h0, 4'h0, 4'h0,
                               4'h0, 2'd0));
    queue_request(make_request(CMD_DEC28,
                               {4'hB, scramble28(pack28(4'h6, 16'hC3C3, 2'd2, 4'h1, 4'h9))},
                               16'h0, 4'h0, 4'h0, 4'h0, 2'd0));
    queue_request(make_request(CMD_DEC28,
                               {4'h0, scramble28(pack28(4'hA, 16'h0F0F, 2'd1, 4'h2, 4'h5))},
                               16'h0, 4'h0, 4'h0, 4'h0, 2'd0));
    queue_request(make_request(CMD_DEC28,
                               {4'hF, scramble28(pack28(4'hF, 16'h0000, 2'd3, 4'h3, 4'hF))},
                               16'h0, 4'h0, 4'h0, 4'h0, 2'd0));
    queue_request(make_request(CMD_DEC32, {4'h0, 4'hF, 16'hFFFF, 8'hFF}, 16'h0, 4'h0, 4'h0,
                               4'h0, 2'd0));
    queue_request(make_request(CMD_ENC28, 32'h0, 16'h1234, 4'h7, 4'h2, 4'h9, 2'd1));
    queue_request(make_request(CMD_ENC32, 32'h0, 16'hFFFF, 4'hF, 4'hF, 4'hF, 2'd3));
    drain_pipeline();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: load_config(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        1: load_config(1'b0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        2: load_config(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        3: begin
          steady = 1'b1;
          load_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        end
        4: load_config(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'hFFFF);
        default: load_config(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom));
      endcase
      for (int n = 0; n < RANDOM_ITEMS; n++) queue_request(random_request());
      drain_pipeline();
      steady = 1'b0;
    end

    if (errors == 0) begin
      $display("** rf_remote_code_cipher: PASSED **");
    end else begin
      $display("** rf_remote_code_cipher: FAILED **");
    end
    $finish;
  end

endmodule
